>>> sv/afld_pkg.sv
// ============================================================================
// afld_pkg: shared types and constants of the frame line decoder
// Beat formats of both channels, line type codes, result kinds and the
// pixel widening function.
// ============================================================================
`default_nettype none

package afld_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    // Line type codes.
    localparam logic [1:0] LT_BLANK = 2'd0;
    localparam logic [1:0] LT_BG0   = 2'd1;
    localparam logic [1:0] LT_BG1   = 2'd2;
    localparam logic [1:0] LT_RAW   = 2'd3;

    // Default word of a background-one line: every pixel set.
    localparam logic [31:0] WORD_ONES = 32'h1111_1111;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_of_frame;
    } t_in;

    typedef struct packed {
        logic [1:0]        kind;
        logic              layer;
        logic [7:0]        line;
        logic [4:0]        word;
        logic [31:0]       data;
        logic              xor_mode;
        logic [7:0]        header_byte;
        logic signed [7:0] shift_x;
        logic signed [7:0] shift_y;
        logic [7:0]        run_lines;
        logic              last;
        logic              frame_done;
    } t_out;

    // Request from the sequencer to the output staging.
    typedef struct packed {
        logic emit;        // res is a new result
        logic flush;       // item finished: release the held result as last
        logic frame_done;  // the finished item closes the frame
        t_out res;
    } t_emit;

    // Each pixel bit becomes the low bit of its own nibble.
    function automatic logic [31:0] widen(input logic [7:0] b);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            w[4*i] = b[i];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/afld_type_mem.sv
// ============================================================================
// afld_type_mem: line type memory
// One row holds the four 2-bit line types of one type byte. One write port
// and one read port with registered read data.
// ============================================================================
`default_nettype none

module afld_type_mem #(
    parameter int DEPTH = 96
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [7:0]               i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/afld_seq.sv
// ============================================================================
// afld_seq: stream parser and line sequencer
// Tracks the frame phase, fills the line type memory, scans it one line at
// a time for blank runs and steps through the words of each line.
// ============================================================================
`default_nettype none

module afld_seq
    import afld_pkg::*;
#(
    parameter int LINES          = 192,
    parameter int WORDS_PER_LINE = 32,
    parameter int DEPTH          = 2 * ((LINES + 3) / 4)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_vld,
    input  wire t_in                      i_in,
    output logic                          o_busy,
    input  wire logic                     i_stage_rdy,
    output t_emit                         o_emit,
    output logic                          o_mem_we,
    output logic      [$clog2(DEPTH)-1:0] o_mem_waddr,
    output logic      [7:0]               o_mem_wdata,
    output logic                          o_mem_re,
    output logic      [$clog2(DEPTH)-1:0] o_mem_raddr,
    input  wire logic [7:0]               i_mem_rdata
);

    localparam int BPL = (LINES + 3) / 4;
    localparam int AW  = $clog2(DEPTH);
    localparam int LW  = $clog2(LINES + 1);
    localparam int CW  = $clog2(WORDS_PER_LINE + 1);

    typedef enum logic [7:0] {
        PH_WAIT   = 8'b0000_0001,
        PH_DX     = 8'b0000_0010,
        PH_DY     = 8'b0000_0100,
        PH_TYPES  = 8'b0000_1000,
        PH_FLAGS  = 8'b0001_0000,
        PH_PIXELS = 8'b0010_0000,
        PH_RAW    = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_EV    = 5'b00100,
        S_FILL  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_seq_st;

    t_seq_st          r_st, n_st;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_hdr, n_hdr;
    logic [7:0]       r_sx, n_sx;
    logic [AW-1:0]    r_tcnt, n_tcnt;
    logic             r_layer, n_layer;
    logic [LW-1:0]    r_line, n_line;
    logic [CW-1:0]    r_chunk, n_chunk;
    logic [31:0]      r_flags, n_flags;
    logic [1:0]       r_fcnt, n_fcnt;
    logic [1:0]       r_ltype, n_ltype;
    logic [LW-1:0]    r_run, n_run;
    logic             r_fdone, n_fdone;

    logic             w_acc;
    logic [7:0]       w_b;
    logic [1:0]       w_type;
    logic             w_flag;
    logic [LW-1:0]    w_start;
    t_emit            w_emit;

    assign w_acc   = i_in_vld && (r_st == S_IDLE);
    assign w_b     = i_in.byte_value;
    assign w_type  = i_mem_rdata[{r_line[1:0], 1'b0} +: 2];
    assign w_flag  = r_flags[~5'(r_chunk)];
    assign w_start = r_line - r_run;

    assign o_busy      = (r_st != S_IDLE);
    assign o_emit      = w_emit;
    assign o_mem_waddr = r_tcnt;
    assign o_mem_wdata = w_b;
    assign o_mem_raddr = r_layer ? AW'(BPL) + AW'(r_line >> 2) : AW'(r_line >> 2);

    always_comb begin
        n_st    = r_st;
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_sx    = r_sx;
        n_tcnt  = r_tcnt;
        n_layer = r_layer;
        n_line  = r_line;
        n_chunk = r_chunk;
        n_flags = r_flags;
        n_fcnt  = r_fcnt;
        n_ltype = r_ltype;
        n_run   = r_run;
        n_fdone = r_fdone;

        o_mem_we = 1'b0;
        o_mem_re = 1'b0;

        w_emit                  = '0;
        w_emit.frame_done       = r_fdone;
        w_emit.res.xor_mode     = !r_hdr[7];
        w_emit.res.layer        = r_layer;
        w_emit.res.line         = 8'(r_line);
        w_emit.res.word         = 5'(r_chunk);

        unique case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    n_fdone = 1'b0;
                    if (i_in.first_of_frame) begin
                        n_hdr   = w_b;
                        n_sx    = '0;
                        n_tcnt  = '0;
                        n_layer = 1'b0;
                        n_line  = '0;
                        n_chunk = '0;
                        n_flags = '0;
                        n_fcnt  = '0;
                        if (!w_b[7] && (w_b[6:5] != 2'b00)) begin
                            n_phase = PH_DX;
                        end else begin
                            w_emit.emit            = 1'b1;
                            w_emit.res.kind        = KIND_HEADER;
                            w_emit.res.xor_mode    = !w_b[7];
                            w_emit.res.layer       = 1'b0;
                            w_emit.res.line        = '0;
                            w_emit.res.word        = '0;
                            w_emit.res.header_byte = w_b;
                            n_phase                = PH_TYPES;
                            n_st                   = S_FLUSH;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_DX: begin
                                n_sx    = w_b;
                                n_phase = PH_DY;
                            end
                            PH_DY: begin
                                w_emit.emit            = 1'b1;
                                w_emit.res.kind        = KIND_HEADER;
                                w_emit.res.layer       = 1'b0;
                                w_emit.res.line        = '0;
                                w_emit.res.word        = '0;
                                w_emit.res.header_byte = r_hdr;
                                w_emit.res.shift_x     = r_sx;
                                w_emit.res.shift_y     = w_b;
                                n_phase                = PH_TYPES;
                                n_st                   = S_FLUSH;
                            end
                            PH_TYPES: begin
                                o_mem_we = 1'b1;
                                n_tcnt   = r_tcnt + 1'b1;
                                if (r_tcnt == AW'(DEPTH - 1)) begin
                                    n_layer = 1'b0;
                                    n_line  = '0;
                                    n_run   = '0;
                                    n_st    = S_RD;
                                end
                            end
                            PH_FLAGS: begin
                                n_flags = {r_flags[23:0], w_b};
                                n_fcnt  = r_fcnt + 1'b1;
                                if (r_fcnt == 2'd3) begin
                                    n_chunk = '0;
                                    n_st    = S_FILL;
                                end
                            end
                            PH_PIXELS: begin
                                w_emit.emit     = 1'b1;
                                w_emit.res.kind = KIND_WORD;
                                w_emit.res.data = widen(w_b);
                                n_chunk         = r_chunk + 1'b1;
                                n_st            = S_FILL;
                            end
                            PH_RAW: begin
                                w_emit.emit     = 1'b1;
                                w_emit.res.kind = KIND_WORD;
                                w_emit.res.data = widen(w_b);
                                n_chunk         = r_chunk + 1'b1;
                                if (r_chunk == CW'(WORDS_PER_LINE - 1)) begin
                                    n_line = r_line + 1'b1;
                                    n_run  = '0;
                                    n_st   = S_RD;
                                end else begin
                                    n_st = S_FLUSH;
                                end
                            end
                            default: begin
                                // Waiting for a header or frame complete:
                                // the byte is dropped.
                            end
                        endcase
                    end
                end
            end

            S_RD: begin
                if (r_line < LW'(LINES)) begin
                    o_mem_re = 1'b1;
                    n_st     = S_EV;
                end else begin
                    // End of the layer: close any open blank run first.
                    w_emit.emit          = (r_run != '0);
                    w_emit.res.kind      = KIND_RUN;
                    w_emit.res.line      = 8'(w_start);
                    w_emit.res.word      = '0;
                    w_emit.res.run_lines = 8'(r_run);
                    if (r_run == '0 || i_stage_rdy) begin
                        n_run = '0;
                        if (!r_layer) begin
                            n_layer = 1'b1;
                            n_line  = '0;
                        end else begin
                            n_phase = PH_DONE;
                            n_fdone = 1'b1;
                            n_st    = S_FLUSH;
                        end
                    end
                end
            end

            S_EV: begin
                if (w_type == LT_BLANK) begin
                    n_line = r_line + 1'b1;
                    n_run  = r_run + 1'b1;
                    n_st   = S_RD;
                end else begin
                    w_emit.emit          = (r_run != '0);
                    w_emit.res.kind      = KIND_RUN;
                    w_emit.res.line      = 8'(w_start);
                    w_emit.res.word      = '0;
                    w_emit.res.run_lines = 8'(r_run);
                    if (r_run == '0 || i_stage_rdy) begin
                        n_run   = '0;
                        n_chunk = '0;
                        n_ltype = w_type;
                        if (w_type == LT_RAW) begin
                            n_phase = PH_RAW;
                        end else begin
                            n_phase = PH_FLAGS;
                            n_fcnt  = '0;
                            n_flags = '0;
                        end
                        n_st = S_FLUSH;
                    end
                end
            end

            S_FILL: begin
                if (r_chunk < CW'(WORDS_PER_LINE)) begin
                    if (!w_flag) begin
                        w_emit.emit     = 1'b1;
                        w_emit.res.kind = KIND_WORD;
                        w_emit.res.data = (r_ltype == LT_BG1) ? WORD_ONES : '0;
                        if (i_stage_rdy) begin
                            n_chunk = r_chunk + 1'b1;
                        end
                    end else begin
                        n_phase = PH_PIXELS;
                        n_st    = S_FLUSH;
                    end
                end else begin
                    n_line = r_line + 1'b1;
                    n_run  = '0;
                    n_st   = S_RD;
                end
            end

            S_FLUSH: begin
                w_emit.flush = 1'b1;
                if (i_stage_rdy) begin
                    n_st = S_IDLE;
                end
            end

            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_phase <= PH_WAIT;
            r_tcnt  <= '0;
            r_layer <= 1'b0;
            r_line  <= '0;
            r_chunk <= '0;
            r_fcnt  <= '0;
            r_run   <= '0;
            r_fdone <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_phase <= n_phase;
            r_tcnt  <= n_tcnt;
            r_layer <= n_layer;
            r_line  <= n_line;
            r_chunk <= n_chunk;
            r_fcnt  <= n_fcnt;
            r_run   <= n_run;
            r_fdone <= n_fdone;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr   <= n_hdr;
        r_sx    <= n_sx;
        r_flags <= n_flags;
        r_ltype <= n_ltype;
    end

endmodule

`default_nettype wire

>>> sv/animation_frame_line_decoder_core.sv
// ============================================================================
// animation_frame_line_decoder_core: two-layer animation frame decoder
// Turns a compressed frame byte stream into header, pixel word and blank
// run results.
// ============================================================================
// Usage: bytes enter on the input channel, one per beat, with first_of_frame
// set on the header byte; that bit restarts decoding at any time. Results
// leave on the output channel, one per beat; last marks the final result of
// an input byte and frame_done the final result of the frame.
// A byte with no result (dx, line types, flag bytes, stray bytes) is simply
// taken. A header, dy or raw byte makes its result as it is accepted, and
// the input stalls until that result is released. After a pixel byte or
// the last flag byte of a line, the sequencer emits each default word in
// turn, then finds the next flagged word and releases. A byte that ends a
// line, and the type byte that ends the table, scan the line type memory
// line by line (a read, then an evaluate), with a step at each layer end,
// then release. The memory has a single read port, and the sequencer makes
// one result per cycle while the staging is ready. A result waits in the
// holding register until the next result or the release moves it out.
// Reset: the block returns to waiting for a header byte, the output channel
// empties. The line type memory needs no clearing, since each frame writes
// it before reading it. When the receiver stalls, the result held at the
// outputs stays, one more waits in the holding stage, and the sequencer
// pauses; the input channel stalls until the byte is fully handled.
// ============================================================================
`default_nettype none

module animation_frame_line_decoder_core
    import afld_pkg::*;
#(
    parameter int LINES          = 192,
    parameter int WORDS_PER_LINE = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_vld,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_vld,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    // Four line types per memory row, one table of rows per layer.
    localparam int DEPTH = 2 * ((LINES + 3) / 4);
    localparam int AW    = $clog2(DEPTH);

    logic          w_busy;
    logic          w_stage_rdy;
    t_emit         w_emit;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [7:0]    w_mem_wdata;
    logic          w_mem_re;
    logic [AW-1:0] w_mem_raddr;
    logic [7:0]    w_mem_rdata;

    // Output staging: a result is kept in the holding register until the
    // sequencer either produces another one (so the held one is not last)
    // or finishes the byte (so it is). Only then does it move to the
    // output register with last and frame_done settled.
    logic r_hold_vld, n_hold_vld;
    t_out r_hold, n_hold;
    logic r_out_vld, n_out_vld;
    t_out r_out, n_out;

    afld_type_mem #(
        .DEPTH (DEPTH)
    ) u_type_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    afld_seq #(
        .LINES          (LINES),
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .DEPTH          (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (i_in_vld),
        .i_in        (i_in),
        .o_busy      (w_busy),
        .i_stage_rdy (w_stage_rdy),
        .o_emit      (w_emit),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // The input is taken only while the sequencer is idle.
    assign o_in_stall = w_busy;

    // The staging can take a new result, or release the held one, when the
    // holding register is empty or the output register frees up this cycle.
    assign w_stage_rdy = !r_hold_vld || !r_out_vld || !i_out_stall;

    always_comb begin
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;
        n_out_vld  = r_out_vld;
        n_out      = r_out;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        if (w_emit.emit && w_stage_rdy) begin
            n_hold     = w_emit.res;
            n_hold_vld = 1'b1;
            if (r_hold_vld) begin
                // Another result follows, so the held one is not the last.
                n_out     = r_hold;
                n_out_vld = 1'b1;
            end
        end else if (w_emit.flush && w_stage_rdy && r_hold_vld) begin
            n_out            = r_hold;
            n_out.last       = 1'b1;
            n_out.frame_done = w_emit.frame_done;
            n_out_vld        = 1'b1;
            n_hold_vld       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_out_vld = r_out_vld;
    assign o_out     = r_out;

`ifndef NO_ASSERTIONS
    // Every byte's results are released before the next byte is taken.
    a_idle_hold_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !r_hold_vld)
        else $error("holding register still full while accepting input");

    // A frame ends only on the last result of a byte.
    a_done_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_vld && o_out.frame_done) |-> o_out.last)
        else $error("frame_done without last");

    // The header result is always the only result of its byte.
    a_header_alone : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_vld && (o_out.kind == KIND_HEADER)) |-> o_out.last)
        else $error("header result not marked last");

    // The sequencer never requests a new result and a release together.
    a_emit_flush_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_emit.emit && w_emit.flush))
        else $error("emit and flush requested in the same cycle");
`endif

endmodule

`default_nettype wire
